/* hw/rtl/ffm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_pkg
// Shared types, sizes, codes and fixed-point helpers of the field-aware
// factorization machine engine (signed Q8.24 arithmetic).
// ----------------------------------------------------------------------------
package ffm_pkg;

    localparam int FEATURES  = 1024;
    localparam int FIELDS    = 16;
    localparam int FACTORS   = 4;
    localparam int MAX_NODES = 32;

    localparam int STORE_WORDS = FEATURES * FIELDS * 2 * FACTORS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int D_W         = $clog2(FACTORS);
    localparam int NB_AW       = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);

    localparam int SIG_TERMS   = 12;

    localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CLAMP15  = 32'sd251658240;
    localparam logic signed [31:0] ONE_Q24  = 32'sh0100_0000;
    localparam logic [31:0]        ONE_Q30  = 32'h4000_0000;
    localparam logic [63:0]        TWO_P48  = 64'h0001_0000_0000_0000;
    localparam logic [63:0]        TWO_P54  = 64'h0040_0000_0000_0000;

    localparam logic [10:0] RST_FEAT_LIM = 11'd1024;
    localparam logic [4:0]  RST_FLD_LIM  = 5'd16;
    localparam logic [30:0] RST_STEP     = 31'd1677722;
    localparam logic [30:0] RST_LAMBDA   = 31'd336;

    localparam logic [1:0] CFG_FEAT_LIM = 2'd0;
    localparam logic [1:0] CFG_FLD_LIM  = 2'd1;
    localparam logic [1:0] CFG_STEP     = 2'd2;
    localparam logic [1:0] CFG_LAMBDA   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [2:0] {
        K_WRITE   = 3'd0,
        K_READ    = 3'd1,
        K_ADD     = 3'd2,
        K_PREDICT = 3'd3,
        K_UPDATE  = 3'd4
    } t_kind;

    typedef enum logic [5:0] {
        S_IDLE, S_EXEC, S_RD_WAIT,
        S_WALK_A, S_WALK_A2, S_WALK_B, S_WALK_B2, S_PV, S_KV,
        S_P_RD1, S_P_RD2, S_P_M1, S_P_M2, S_P_ACC,
        S_U_RD0, S_U_RD1, S_U_RD2, S_U_RD3, S_U_RD4,
        S_U_G1A, S_U_G1B, S_U_G2A, S_U_G2B, S_U_S1, S_U_S2,
        S_U_RS, S_U_SQ, S_U_DV, S_U_RM, S_U_RM2, S_U_RM3,
        S_U_WR0, S_U_WR1, S_U_WR2, S_U_WR3,
        S_SG_INIT, S_SG_T, S_SG_T2, S_SG_DIV, S_SG_SQ, S_SG_SQ2,
        S_SG_DEN, S_SG_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [19:0]        feat;
        logic [7:0]         fld;
        logic signed [31:0] val;
    } t_node;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] q;
    } t_satq;

    function automatic t_satq sat32(input logic signed [63:0] v);
        t_satq r;
        r.sat = 1'b0;
        r.q   = v[31:0];
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.q   = Q_MAX;
        end else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.q   = 32'sh8000_0000;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ffm_wmem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_wmem
// Single-port weight store, one word written or read per cycle, registered
// read data (read-first).
// ----------------------------------------------------------------------------
module ffm_wmem (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [ffm_pkg::ADDR_W-1:0]  i_addr,
    input  wire logic signed [31:0]          i_wdata,
    output logic signed [31:0]               o_rdata
);
    import ffm_pkg::*;

    logic signed [31:0] r_mem [STORE_WORDS];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/ffm_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_mul
// Shared 32x32 signed multiplier with registered product, plus the Q8.24
// floor-and-saturate view of that product.
// ----------------------------------------------------------------------------
module ffm_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_prod,
    output ffm_pkg::t_satq          o_res
);
    import ffm_pkg::*;

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
    // arithmetic shift is the floor of the Q8.24 product
    assign o_res  = sat32(r_prod >>> 24);

endmodule
`default_nettype wire

/* hw/rtl/ffm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_div
// Unsigned 64 by 32 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ffm_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    import ffm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] rem_sh;
    logic        fit;

    assign rem_sh = {r_rem[31:0], r_quo[63]};
    assign fit    = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fit ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_quo <= {r_quo[62:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

/* hw/rtl/ffm_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_sqrt
// Integer square root of a 64-bit value, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ffm_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_rad,
    output logic             o_done,
    output logic [31:0]      o_root
);
    import ffm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;
    logic        ge;

    assign trial = r_res + r_bit;
    assign ge    = r_n >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_rad;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (ge) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule
`default_nettype wire

/* hw/rtl/ffm_pairwise_score_adagrad_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Predict walks every pair of live nodes on the shared multiplier and ends with the bit-serial
// divider for the final sigmoid quotient; update runs a sqrt and a divide per rsqrt.
// One item at a time, o_busy high meanwhile; no result stall is possible.
// Reset clears control, node count and last prediction and loads config defaults; memories undefined.
// ----------------------------------------------------------------------------
// ffm_pairwise_score_adagrad_unit
// Field-aware factorization machine engine: weight store access, node buffer,
// pairwise score with sigmoid and in-place AdaGrad update on shared units.
// ----------------------------------------------------------------------------
module ffm_pairwise_score_adagrad_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [2:0]         i_kind,
    input  wire logic [16:0]        i_word_address,
    input  wire logic signed [31:0] i_word_data,
    input  wire logic [19:0]        i_feature_index,
    input  wire logic [7:0]         i_field_index,
    input  wire logic signed [31:0] i_node_value,
    input  wire logic               i_first_node,
    input  wire logic               i_label,
    output logic                    o_done,
    output logic [24:0]             o_prediction,
    output logic signed [31:0]      o_raw_score,
    output logic signed [31:0]      o_read_data,
    output logic [1:0]              o_status,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import ffm_pkg::*;

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [24:0]        r_last_pred, n_last_pred;
    logic [10:0]        r_feat_lim;
    logic [4:0]         r_fld_lim;
    logic [30:0]        r_step;
    logic [30:0]        r_lambda;

    // working registers
    logic [2:0]         r_kind, n_kind;
    logic [16:0]        r_addr, n_addr;
    logic signed [31:0] r_wdata, n_wdata;
    logic [19:0]        r_feat, n_feat;
    logic [7:0]         r_fld, n_fld;
    logic signed [31:0] r_val, n_val;
    logic               r_first, n_first;
    logic [CNT_W-1:0]   r_a, n_a, r_b, n_b;
    logic [D_W-1:0]     r_d, n_d;
    t_node              r_n1, n_n1, r_n2, n_n2;
    logic signed [31:0] r_v, n_v, r_kv, n_kv, r_kappa, n_kappa;
    logic signed [31:0] r_w1, n_w1, r_w2, n_w2, r_s1, n_s1, r_s2, n_s2;
    logic signed [31:0] r_g1, n_g1, r_g2, n_g2, r_t, n_t, r_rs, n_rs;
    logic               r_sel, n_sel;
    logic signed [63:0] r_acc, n_acc;
    logic               r_sat, n_sat, r_drop, n_drop;
    logic [31:0]        r_term, n_term;
    logic signed [32:0] r_sum, n_sum;
    logic [29:0]        r_x4, n_x4;
    logic               r_neg, n_neg;
    logic [3:0]         r_k, n_k;
    logic [1:0]         r_j, n_j;
    logic [24:0]        r_pred, n_pred;
    logic signed [31:0] r_raw, n_raw, r_rd, n_rd;

    // unit connections
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic signed [31:0] mem_wdata, mem_rdata;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_prod;
    t_satq              mq;
    logic               div_start, div_done;
    logic [63:0]        div_dividend, div_quot;
    logic [31:0]        div_divisor;
    logic               sqrt_start, sqrt_done;
    logic [63:0]        sqrt_rad;
    logic [31:0]        sqrt_root;

    // node buffer
    t_node              r_nb_mem [MAX_NODES];
    t_node              r_nb_q;
    logic               nb_we;
    logic [NB_AW-1:0]   nb_waddr, nb_raddr;
    t_node              nb_wdata;

    logic [ADDR_W-1:0]  p1, p2, p1_w, p2_w, p1_s, p2_s;
    logic [31:0]        feat_lim, fld_lim;

    function automatic logic [ADDR_W-1:0] pair_base(input logic [19:0] feat,
                                                    input logic [7:0] fld);
        logic [47:0] t;
        t = (48'(feat) * 48'(FIELDS) + 48'(fld)) * 48'(2 * FACTORS);
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic node_ok(input t_node n, input logic [31:0] flim,
                                     input logic [31:0] dlim);
        return (32'(n.feat) < flim) && (32'(n.fld) < dlim);
    endfunction

    // floor(q / k) = (q * recip_k(k)) >> recip_shift(k), exact for q below 2^30
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        case (k)
            4'd3:    return 32'd1431655766;
            4'd5:    return 32'd1717986919;
            4'd6:    return 32'd1431655766;
            4'd7:    return 32'd1227133514;
            4'd9:    return 32'd1908874354;
            4'd10:   return 32'd1717986919;
            4'd11:   return 32'd1561806290;
            4'd12:   return 32'd1431655766;
            default: return 32'd1073741824;
        endcase
    endfunction

    function automatic logic [5:0] recip_shift(input logic [3:0] k);
        case (k)
            4'd2:                 return 6'd31;
            4'd3, 4'd4:           return 6'd32;
            4'd5, 4'd6, 4'd7, 4'd8: return 6'd33;
            4'd9, 4'd10, 4'd11, 4'd12: return 6'd34;
            default:              return 6'd30;
        endcase
    endfunction

    ffm_wmem u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ffm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod),
        .o_res  (mq)
    );

    ffm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    ffm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            r_nb_mem[nb_waddr] <= nb_wdata;
        end
        r_nb_q <= r_nb_mem[nb_raddr];
    end

    assign feat_lim = (32'(r_feat_lim) < 32'(FEATURES)) ? 32'(r_feat_lim) : 32'(FEATURES);
    assign fld_lim  = (32'(r_fld_lim) < 32'(FIELDS)) ? 32'(r_fld_lim) : 32'(FIELDS);

    // w1 lives at (feature 1, field 2), w2 at (feature 2, field 1)
    assign p1   = pair_base(r_n1.feat, r_n2.fld);
    assign p2   = pair_base(r_n2.feat, r_n1.fld);
    assign p1_w = p1 + ADDR_W'(r_d);
    assign p2_w = p2 + ADDR_W'(r_d);
    assign p1_s = p1 + ADDR_W'(FACTORS) + ADDR_W'(r_d);
    assign p2_s = p2 + ADDR_W'(FACTORS) + ADDR_W'(r_d);

    always_comb begin
        logic [CNT_W-1:0]   cnt;
        t_satq              sq;
        logic signed [31:0] s, c, wsel;
        logic [27:0]        x;
        logic [31:0]        den;
        logic [63:0]        kq;

        n_state     = r_state;
        n_count     = r_count;
        n_last_pred = r_last_pred;
        n_kind  = r_kind;   n_addr  = r_addr;   n_wdata = r_wdata;
        n_feat  = r_feat;   n_fld   = r_fld;    n_val   = r_val;
        n_first = r_first;
        n_a = r_a;   n_b = r_b;   n_d = r_d;
        n_n1 = r_n1; n_n2 = r_n2;
        n_v = r_v;   n_kv = r_kv; n_kappa = r_kappa;
        n_w1 = r_w1; n_w2 = r_w2; n_s1 = r_s1; n_s2 = r_s2;
        n_g1 = r_g1; n_g2 = r_g2; n_t = r_t;   n_rs = r_rs;
        n_sel = r_sel; n_acc = r_acc; n_sat = r_sat; n_drop = r_drop;
        n_term = r_term; n_sum = r_sum; n_x4 = r_x4; n_neg = r_neg;
        n_k = r_k; n_j = r_j;
        n_pred = r_pred; n_raw = r_raw; n_rd = r_rd;

        mem_we       = 1'b0;
        mem_addr     = p1_w;
        mem_wdata    = r_w1;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sqrt_start   = 1'b0;
        sqrt_rad     = '0;
        nb_we        = 1'b0;
        nb_waddr     = '0;
        nb_wdata     = '{feat: r_feat, fld: r_fld, val: r_val};
        nb_raddr     = r_a[NB_AW-1:0];

        cnt  = '0;
        sq   = '{sat: 1'b0, q: '0};
        s    = '0;
        c    = '0;
        wsel = '0;
        x    = '0;
        den  = '0;
        kq   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind  = i_kind;
                    n_addr  = i_word_address;
                    n_wdata = i_word_data;
                    n_feat  = i_feature_index;
                    n_fld   = i_field_index;
                    n_val   = i_node_value;
                    n_first = i_first_node;
                    n_kappa = $signed({7'b0, r_last_pred}) - (i_label ? ONE_Q24 : 32'sd0);
                    n_pred  = '0;
                    n_raw   = '0;
                    n_rd    = '0;
                    n_sat   = 1'b0;
                    n_drop  = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                mem_addr  = ADDR_W'(r_addr);
                mem_wdata = r_wdata;
                n_a       = '0;
                n_acc     = '0;
                n_state   = S_DONE;
                case (r_kind)
                    K_WRITE: begin
                        mem_we = 32'(r_addr) < 32'(STORE_WORDS);
                    end
                    K_READ: begin
                        n_state = S_RD_WAIT;
                    end
                    K_ADD: begin
                        cnt = r_first ? '0 : r_count;
                        if (32'(cnt) < 32'(MAX_NODES)) begin
                            nb_we    = 1'b1;
                            nb_waddr = cnt[NB_AW-1:0];
                            n_count  = cnt + CNT_W'(1);
                        end else begin
                            n_count = cnt;
                            n_drop  = 1'b1;
                        end
                    end
                    K_PREDICT, K_UPDATE: begin
                        n_state = S_WALK_A;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                n_rd    = (32'(r_addr) < 32'(STORE_WORDS)) ? mem_rdata : 32'sd0;
                n_state = S_DONE;
            end
            S_WALK_A: begin
                if (r_a >= r_count) begin
                    n_state = (r_kind == K_PREDICT) ? S_SG_INIT : S_DONE;
                end else begin
                    n_state = S_WALK_A2;
                end
            end
            S_WALK_A2: begin
                n_n1 = r_nb_q;
                if (node_ok(r_nb_q, feat_lim, fld_lim)) begin
                    n_b     = r_a + CNT_W'(1);
                    n_state = S_WALK_B;
                end else begin
                    n_a     = r_a + CNT_W'(1);
                    n_state = S_WALK_A;
                end
            end
            S_WALK_B: begin
                nb_raddr = r_b[NB_AW-1:0];
                if (r_b >= r_count) begin
                    n_a     = r_a + CNT_W'(1);
                    n_state = S_WALK_A;
                end else begin
                    n_state = S_WALK_B2;
                end
            end
            S_WALK_B2: begin
                n_n2 = r_nb_q;
                n_d  = '0;
                if (node_ok(r_nb_q, feat_lim, fld_lim)) begin
                    mul_a   = r_n1.val;
                    mul_b   = r_nb_q.val;
                    n_state = S_PV;
                end else begin
                    n_b     = r_b + CNT_W'(1);
                    n_state = S_WALK_B;
                end
            end
            S_PV: begin
                n_v   = mq.q;
                n_sat = r_sat | mq.sat;
                if (r_kind == K_PREDICT) begin
                    n_state = S_P_RD1;
                end else begin
                    mul_a   = r_kappa;
                    mul_b   = mq.q;
                    n_state = S_KV;
                end
            end
            S_KV: begin
                n_kv    = mq.q;
                n_sat   = r_sat | mq.sat;
                n_state = S_U_RD0;
            end
            // predict: acc += (w1*w2)*v per factor
            S_P_RD1: begin
                mem_addr = p1_w;
                n_state  = S_P_RD2;
            end
            S_P_RD2: begin
                mem_addr = p2_w;
                n_w1     = mem_rdata;
                n_state  = S_P_M1;
            end
            S_P_M1: begin
                mul_a   = r_w1;
                mul_b   = mem_rdata;
                n_state = S_P_M2;
            end
            S_P_M2: begin
                n_sat   = r_sat | mq.sat;
                mul_a   = mq.q;
                mul_b   = r_v;
                n_state = S_P_ACC;
            end
            S_P_ACC: begin
                n_sat = r_sat | mq.sat;
                n_acc = r_acc + sext32(mq.q);
                if (r_d == D_W'(FACTORS - 1)) begin
                    n_d     = '0;
                    n_b     = r_b + CNT_W'(1);
                    n_state = S_WALK_B;
                end else begin
                    n_d     = r_d + D_W'(1);
                    n_state = S_P_RD1;
                end
            end
            // update: fetch w1, w2, s1, s2
            S_U_RD0: begin
                mem_addr = p1_w;
                n_state  = S_U_RD1;
            end
            S_U_RD1: begin
                mem_addr = p2_w;
                n_w1     = mem_rdata;
                n_state  = S_U_RD2;
            end
            S_U_RD2: begin
                mem_addr = p1_s;
                n_w2     = mem_rdata;
                n_state  = S_U_RD3;
            end
            S_U_RD3: begin
                mem_addr = p2_s;
                n_s1     = mem_rdata;
                n_state  = S_U_RD4;
            end
            S_U_RD4: begin
                n_s2    = mem_rdata;
                mul_a   = $signed({1'b0, r_lambda});
                mul_b   = r_w1;
                n_state = S_U_G1A;
            end
            S_U_G1A: begin
                n_t     = mq.q;
                n_sat   = r_sat | mq.sat;
                mul_a   = r_kv;
                mul_b   = r_w2;
                n_state = S_U_G1B;
            end
            S_U_G1B: begin
                sq      = sat32(sext32(r_t) + sext32(mq.q));
                n_g1    = sq.q;
                n_sat   = r_sat | mq.sat | sq.sat;
                mul_a   = $signed({1'b0, r_lambda});
                mul_b   = r_w2;
                n_state = S_U_G2A;
            end
            S_U_G2A: begin
                n_t     = mq.q;
                n_sat   = r_sat | mq.sat;
                mul_a   = r_kv;
                mul_b   = r_w1;
                n_state = S_U_G2B;
            end
            S_U_G2B: begin
                sq      = sat32(sext32(r_t) + sext32(mq.q));
                n_g2    = sq.q;
                n_sat   = r_sat | mq.sat | sq.sat;
                mul_a   = r_g1;
                mul_b   = r_g1;
                n_state = S_U_S1;
            end
            S_U_S1: begin
                sq      = sat32(sext32(r_s1) + sext32(mq.q));
                n_s1    = sq.q;
                n_sat   = r_sat | mq.sat | sq.sat;
                mul_a   = r_g2;
                mul_b   = r_g2;
                n_state = S_U_S2;
            end
            S_U_S2: begin
                sq      = sat32(sext32(r_s2) + sext32(mq.q));
                n_s2    = sq.q;
                n_sat   = r_sat | mq.sat | sq.sat;
                n_sel   = 1'b0;
                n_state = S_U_RS;
            end
            // rsqrt of the selected gradient sum
            S_U_RS: begin
                s = r_sel ? r_s2 : r_s1;
                if (s <= 32'sd0) begin
                    n_rs    = Q_MAX;
                    n_sat   = 1'b1;
                    n_state = S_U_RM;
                end else begin
                    sqrt_start = 1'b1;
                    sqrt_rad   = {8'b0, s, 24'b0};
                    n_state    = S_U_SQ;
                end
            end
            S_U_SQ: begin
                if (sqrt_done) begin
                    div_start    = 1'b1;
                    div_dividend = TWO_P48;
                    div_divisor  = sqrt_root;
                    n_state      = S_U_DV;
                end
            end
            S_U_DV: begin
                if (div_done) begin
                    if (|div_quot[63:31]) begin
                        n_rs  = Q_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_rs = $signed(div_quot[31:0]);
                    end
                    n_state = S_U_RM;
                end
            end
            S_U_RM: begin
                mul_a   = r_rs;
                mul_b   = r_sel ? r_g2 : r_g1;
                n_state = S_U_RM2;
            end
            S_U_RM2: begin
                n_sat   = r_sat | mq.sat;
                mul_a   = $signed({1'b0, r_step});
                mul_b   = mq.q;
                n_state = S_U_RM3;
            end
            S_U_RM3: begin
                wsel  = r_sel ? r_w2 : r_w1;
                sq    = sat32(sext32(wsel) - sext32(mq.q));
                n_sat = r_sat | mq.sat | sq.sat;
                if (r_sel) begin
                    n_w2    = sq.q;
                    n_state = S_U_WR0;
                end else begin
                    n_w1    = sq.q;
                    n_sel   = 1'b1;
                    n_state = S_U_RS;
                end
            end
            // store back in pair order; the w2 side wins on a shared word
            S_U_WR0: begin
                mem_we    = 1'b1;
                mem_addr  = p1_w;
                mem_wdata = r_w1;
                n_state   = S_U_WR1;
            end
            S_U_WR1: begin
                mem_we    = 1'b1;
                mem_addr  = p2_w;
                mem_wdata = r_w2;
                n_state   = S_U_WR2;
            end
            S_U_WR2: begin
                mem_we    = 1'b1;
                mem_addr  = p1_s;
                mem_wdata = r_s1;
                n_state   = S_U_WR3;
            end
            S_U_WR3: begin
                mem_we    = 1'b1;
                mem_addr  = p2_s;
                mem_wdata = r_s2;
                if (r_d == D_W'(FACTORS - 1)) begin
                    n_d     = '0;
                    n_b     = r_b + CNT_W'(1);
                    n_state = S_WALK_B;
                end else begin
                    n_d     = r_d + D_W'(1);
                    n_state = S_U_RD0;
                end
            end
            // sigmoid: e^-x by series on x/16, squared four times
            S_SG_INIT: begin
                sq    = sat32(r_acc);
                n_raw = sq.q;
                n_sat = r_sat | sq.sat;
                if (sq.q > CLAMP15) begin
                    c = CLAMP15;
                end else if (sq.q < -CLAMP15) begin
                    c = -CLAMP15;
                end else begin
                    c = sq.q;
                end
                n_neg   = c[31];
                x       = c[31] ? 28'(-c) : c[27:0];
                n_x4    = {x, 2'b00};
                n_term  = ONE_Q30;
                n_sum   = $signed({1'b0, ONE_Q30});
                n_k     = 4'd1;
                n_state = S_SG_T;
            end
            S_SG_T: begin
                mul_a   = $signed(r_term);
                mul_b   = $signed({2'b00, r_x4});
                n_state = S_SG_T2;
            end
            S_SG_T2: begin
                // term*r stays below 2^60, so the Q.30 product fits 30 bits
                mul_a   = $signed({2'b00, mul_prod[59:30]});
                mul_b   = $signed(recip_k(r_k));
                n_state = S_SG_DIV;
            end
            S_SG_DIV: begin
                kq     = mul_prod >> recip_shift(r_k);
                n_term = kq[31:0];
                if (r_k[0]) begin
                    n_sum = r_sum - $signed({1'b0, kq[31:0]});
                end else begin
                    n_sum = r_sum + $signed({1'b0, kq[31:0]});
                end
                if (r_k == 4'(SIG_TERMS)) begin
                    n_j     = '0;
                    n_state = S_SG_SQ;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_SG_T;
                end
            end
            S_SG_SQ: begin
                mul_a   = r_sum[31:0];
                mul_b   = r_sum[31:0];
                n_state = S_SG_SQ2;
            end
            S_SG_SQ2: begin
                n_sum = $signed({1'b0, mul_prod[61:30]});
                n_j   = r_j + 2'd1;
                n_state = (r_j == 2'd3) ? S_SG_DEN : S_SG_SQ;
            end
            S_SG_DEN: begin
                den          = ONE_Q30 + r_sum[31:0];
                div_start    = 1'b1;
                div_dividend = (r_neg ? {8'b0, r_sum[31:0], 24'b0} : TWO_P54)
                             + {32'b0, den >> 1};
                div_divisor  = den;
                n_state      = S_SG_FIN;
            end
            S_SG_FIN: begin
                if (div_done) begin
                    n_pred      = div_quot[24:0];
                    n_last_pred = div_quot[24:0];
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last_pred <= '0;
            r_feat_lim  <= RST_FEAT_LIM;
            r_fld_lim   <= RST_FLD_LIM;
            r_step      <= RST_STEP;
            r_lambda    <= RST_LAMBDA;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last_pred <= n_last_pred;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FEAT_LIM: r_feat_lim <= i_cfg_data[10:0];
                    CFG_FLD_LIM:  r_fld_lim  <= i_cfg_data[4:0];
                    CFG_STEP:     r_step     <= i_cfg_data[30:0];
                    CFG_LAMBDA:   r_lambda   <= i_cfg_data[30:0];
                    default:      r_step     <= r_step;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;   r_addr  <= n_addr;   r_wdata <= n_wdata;
        r_feat  <= n_feat;   r_fld   <= n_fld;    r_val   <= n_val;
        r_first <= n_first;
        r_a <= n_a;   r_b <= n_b;   r_d <= n_d;
        r_n1 <= n_n1; r_n2 <= n_n2;
        r_v <= n_v;   r_kv <= n_kv; r_kappa <= n_kappa;
        r_w1 <= n_w1; r_w2 <= n_w2; r_s1 <= n_s1; r_s2 <= n_s2;
        r_g1 <= n_g1; r_g2 <= n_g2; r_t <= n_t;   r_rs <= n_rs;
        r_sel <= n_sel; r_acc <= n_acc; r_sat <= n_sat; r_drop <= n_drop;
        r_term <= n_term; r_sum <= n_sum; r_x4 <= n_x4; r_neg <= n_neg;
        r_k <= n_k; r_j <= n_j;
        r_pred <= n_pred; r_raw <= n_raw; r_rd <= n_rd;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_prediction = r_pred;
    assign o_raw_score  = r_raw;
    assign o_read_data  = r_rd;
    assign o_status     = r_drop ? ST_DROP : (r_sat ? ST_SAT : ST_OK);
    assign o_cfg_ready  = 1'b1;

endmodule
`default_nettype wire
